// File: hw/rtl/tpf_pkg.sv
// Shared types, character codes and register indexes of the text page formatter.
package tpf_pkg;

  localparam int ColW  = 16;
  localparam int LineW = 9;
  localparam int MargW = 5;
  localparam int PageW = 8;
  localparam int RunW  = 6;

  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_DATA  = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  localparam logic [1:0] REG_TOP_MARGIN  = 2'd0;
  localparam logic [1:0] REG_LEFT_MARGIN = 2'd1;
  localparam logic [1:0] REG_PAGE_LINES  = 2'd2;

  localparam logic [PageW-1:0] PAGE_LINES_RESET = 8'd60;

  localparam logic [7:0] CH_EOF = 8'h1A;
  localparam logic [7:0] CH_FF  = 8'h0C;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic [3:0] TAB_STOP = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;  // take the request, plan its output bytes, update state
    logic pop;   // move the next planned byte into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic plan_empty;  // the offered request produces no bytes
    logic pop_last;    // the byte popped now is the last one planned
    logic slot_free;   // output register can take a byte this cycle
  } sts_t;

endpackage

// File: hw/rtl/tpf_ctrl.sv
// Controller state machine: request intake and byte sequencing.
module tpf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  tpf_pkg::sts_t sts,
  output tpf_pkg::cmd_t cmd
);

  tpf_pkg::state_t state;
  tpf_pkg::state_t state_next;

  assign in_ready = (state == tpf_pkg::ST_IDLE);
  assign cmd.load = in_valid && in_ready;
  assign cmd.pop  = (state == tpf_pkg::ST_EMIT) && sts.slot_free;

  always_comb begin
    state_next = state;
    case (state)
      tpf_pkg::ST_IDLE: begin
        if (cmd.load && !sts.plan_empty) state_next = tpf_pkg::ST_EMIT;
      end
      tpf_pkg::ST_EMIT: begin
        if (cmd.pop && sts.pop_last) state_next = tpf_pkg::ST_IDLE;
      end
      default: state_next = tpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_plan_starts_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.load && !sts.plan_empty |=> state == tpf_pkg::ST_EMIT)
    else $error("planned bytes did not start sequencing");

  a_empty_plan_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load && sts.plan_empty |=> state == tpf_pkg::ST_IDLE)
    else $error("request without bytes left the intake state");

  a_last_pop_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.pop && sts.pop_last |=> state == tpf_pkg::ST_IDLE)
    else $error("sequencer did not return to intake after last byte");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    state == tpf_pkg::ST_EMIT && !sts.slot_free |=> state == tpf_pkg::ST_EMIT)
    else $error("sequencer left while output was stalled");

endmodule

// File: hw/rtl/tpf_dp.sv
// Datapath: configuration, page state, byte plan and output register.
module tpf_dp (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_write,
  input  logic [1:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  input  logic [1:0]    action,
  input  logic [7:0]    data_byte,
  input  tpf_pkg::cmd_t cmd,
  output tpf_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last
);

  logic [tpf_pkg::MargW-1:0] top_margin;
  logic [tpf_pkg::MargW-1:0] left_margin;
  logic [tpf_pkg::PageW-1:0] page_lines;

  logic [tpf_pkg::ColW-1:0]  column_count;
  logic [tpf_pkg::LineW-1:0] line_count;
  logic                      stopped;

  // planned bytes: two single bytes, then a line feed run, then a space run
  logic                      have1, have2;
  logic [7:0]                b1, b2;
  logic [tpf_pkg::MargW-1:0] lf_cnt;
  logic [tpf_pkg::RunW-1:0]  sp_cnt;

  logic                      p_have1, p_have2;
  logic [7:0]                p_b1, p_b2;
  logic [tpf_pkg::MargW-1:0] p_lf;
  logic [tpf_pkg::RunW-1:0]  p_sp;
  logic [tpf_pkg::ColW-1:0]  column_next;
  logic [tpf_pkg::LineW-1:0] line_next;
  logic                      stopped_next;
  logic [tpf_pkg::LineW-1:0] line_inc;
  logic [3:0]                tab_n;

  assign line_inc = line_count + 9'd1;
  assign tab_n    = tpf_pkg::TAB_STOP - {1'b0, column_count[2:0]};

  always_comb begin
    p_have1      = 1'b0;
    p_have2      = 1'b0;
    p_b1         = data_byte;
    p_b2         = tpf_pkg::CH_CR;
    p_lf         = '0;
    p_sp         = '0;
    column_next  = column_count;
    line_next    = line_count;
    stopped_next = stopped;
    case (action)
      tpf_pkg::ACT_START: begin
        p_have1      = 1'b1;
        p_b1         = tpf_pkg::CH_FF;
        p_have2      = 1'b1;
        p_b2         = tpf_pkg::CH_CR;
        p_lf         = top_margin;
        p_sp         = {1'b0, left_margin};
        column_next  = '0;
        line_next    = '0;
        stopped_next = 1'b0;
      end
      tpf_pkg::ACT_DATA: begin
        if (!stopped) begin
          if (data_byte == tpf_pkg::CH_CR) begin
            p_have1     = 1'b1;
            column_next = '0;
          end else if (data_byte == tpf_pkg::CH_LF) begin
            p_have1   = 1'b1;
            line_next = line_inc;
            if (line_inc > {1'b0, page_lines}) begin
              p_have2   = 1'b1;
              p_b2      = tpf_pkg::CH_FF;
              p_lf      = top_margin;
              line_next = '0;
            end
            if (column_count < {11'd0, left_margin}) begin
              p_sp = {1'b0, left_margin - column_count[tpf_pkg::MargW-1:0]};
            end
          end else if (data_byte == tpf_pkg::CH_FF) begin
            p_have1     = 1'b1;
            p_have2     = 1'b1;
            p_b2        = tpf_pkg::CH_CR;
            p_lf        = top_margin;
            p_sp        = {1'b0, left_margin};
            column_next = '0;
            line_next   = '0;
          end else if (data_byte == tpf_pkg::CH_TAB) begin
            p_sp        = {2'b00, tab_n};
            column_next = column_count + {12'd0, tab_n};
          end else if (data_byte == tpf_pkg::CH_EOF) begin
            p_have1      = 1'b1;
            stopped_next = 1'b1;
          end else begin
            p_have1     = 1'b1;
            column_next = column_count + 16'd1;
          end
        end
      end
      tpf_pkg::ACT_END: begin
        if (!stopped) begin
          p_have1      = 1'b1;
          p_b1         = tpf_pkg::CH_FF;
          p_have2      = 1'b1;
          p_b2         = tpf_pkg::CH_EOF;
          stopped_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.plan_empty = !p_have1 && !p_have2 && (p_lf == '0) && (p_sp == '0);
  assign sts.slot_free  = !out_valid || out_ready;

  logic [7:0] pop_byte;
  logic       pop_last;

  always_comb begin
    if (have1) begin
      pop_byte = b1;
      pop_last = !have2 && (lf_cnt == '0) && (sp_cnt == '0);
    end else if (have2) begin
      pop_byte = b2;
      pop_last = (lf_cnt == '0) && (sp_cnt == '0);
    end else if (lf_cnt != '0) begin
      pop_byte = tpf_pkg::CH_LF;
      pop_last = (lf_cnt == 5'd1) && (sp_cnt == '0);
    end else begin
      pop_byte = tpf_pkg::CH_SP;
      pop_last = (sp_cnt == 6'd1);
    end
  end

  assign sts.pop_last = pop_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_margin   <= '0;
      left_margin  <= '0;
      page_lines   <= tpf_pkg::PAGE_LINES_RESET;
      column_count <= '0;
      line_count   <= '0;
      stopped      <= 1'b0;
      have1        <= 1'b0;
      have2        <= 1'b0;
      lf_cnt       <= '0;
      sp_cnt       <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          tpf_pkg::REG_TOP_MARGIN:  top_margin  <= cfg_data[tpf_pkg::MargW-1:0];
          tpf_pkg::REG_LEFT_MARGIN: left_margin <= cfg_data[tpf_pkg::MargW-1:0];
          tpf_pkg::REG_PAGE_LINES:  page_lines  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        column_count <= column_next;
        line_count   <= line_next;
        stopped      <= stopped_next;
        have1        <= p_have1;
        have2        <= p_have2;
        lf_cnt       <= p_lf;
        sp_cnt       <= p_sp;
      end else if (cmd.pop) begin
        if (have1) begin
          have1 <= 1'b0;
        end else if (have2) begin
          have2 <= 1'b0;
        end else if (lf_cnt != '0) begin
          lf_cnt <= lf_cnt - 5'd1;
        end else begin
          sp_cnt <= sp_cnt - 6'd1;
        end
      end
      if (cmd.pop) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // planned bytes need no reset; the flags and counts above guard them
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      b1 <= p_b1;
      b2 <= p_b2;
    end
    if (cmd.pop) begin
      out_byte <= pop_byte;
      last     <= pop_last;
    end
  end

endmodule

// File: hw/rtl/text_page_formatter.sv
// Top level of the text page formatter: printer byte stream with margins and paging.
//
//   channel   direction  handshake            payload
//   in        sink       in_valid/in_ready    action, data_byte
//   out       source     out_valid/out_ready  out_byte, last
//   cfg       sink       cfg_write            cfg_index, cfg_data
//
// A request is taken in and planned on its handshake; its output bytes (1 to 64)
// then leave at one byte per cycle while the single output byte register is free.
// A request that gives no bytes leaves the block ready for the next one. The next
// request is taken while the previous one's last byte waits in that register.
// Synchronous reset clears the page state and loads the register defaults
// (margins 0, page length 60). Holding out_ready low freezes the sequencer.
module text_page_formatter (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last,
  // register writes: 0 top margin, 1 left margin, 2 page length
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  tpf_pkg::cmd_t cmd;
  tpf_pkg::sts_t sts;

  // Controller: accept a request in idle, then pop one planned byte per free
  // output slot until the plan is drained.
  tpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: on load, decode the request into up to two single bytes, a line
  // feed run and a space run, and update column, line and stop state; on pop,
  // drain the plan in that order into the output register.
  tpf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (action),
    .data_byte (data_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

endmodule

// File: bench/testbench.sv
// Self-checking testbench of the text page formatter: directed and random requests.
`timescale 1ns / 100ps

module testbench;

  // Action code outside the defined set; the block must take it and stay silent.
  localparam logic [1:0] ACT_RESERVED = 2'd3;
  // Register index with no register behind it; writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // A request never plans more bytes than this.
  localparam int MAX_RUN = 64;
  // Cycles with no handshake on either channel before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Cycles to let pass after the last byte, so a request that plans nothing retires.
  localparam int HOLD_OFF = 4;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } print_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [1:0] action = tpf_pkg::ACT_START;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last;
  logic       cfg_write = 1'b0;
  logic [1:0] cfg_index = tpf_pkg::REG_TOP_MARGIN;
  logic [7:0] cfg_data = 8'h00;

  text_page_formatter i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Printer model: own copy of the registers and the page state.
  // ---------------------------------------------------------------------------
  logic [tpf_pkg::MargW-1:0] top_lines;
  logic [tpf_pkg::MargW-1:0] left_spaces;
  logic [tpf_pkg::PageW-1:0] page_len;
  logic [tpf_pkg::ColW-1:0]  col_pos;
  logic [tpf_pkg::LineW-1:0] line_pos;
  logic                      halted;

  print_byte_t printer_stream[$];  // bytes still owed by the block, oldest first
  print_byte_t run_bytes[$];       // bytes planned for the request being modeled
  int          request_bytes;      // how many bytes the last modeled request gave

  int  mismatches = 0;
  bit  quiet_in = 1'b0;   // sender never pauses
  bit  quiet_out = 1'b0;  // receiver never stalls

  function automatic void reset_printer();
    top_lines   = '0;
    left_spaces = '0;
    page_len    = tpf_pkg::PAGE_LINES_RESET;
    col_pos     = '0;
    line_pos    = '0;
    halted      = 1'b0;
  endfunction

  function automatic void put_char(input logic [7:0] ch);
    if (run_bytes.size() < MAX_RUN) run_bytes.push_back('{ch, 1'b0});
  endfunction

  function automatic void put_run(input logic [7:0] ch, input int count);
    for (int i = 0; i < count; i++) put_char(ch);
  endfunction

  // Work out the bytes that one request gives and move the page state on.
  function automatic void format_request(input logic [1:0] act, input logic [7:0] db);
    int          tab_fill;
    print_byte_t tail;
    run_bytes.delete();
    case (act)
      tpf_pkg::ACT_START: begin
        halted   = 1'b0;
        col_pos  = '0;
        line_pos = '0;
        put_char(tpf_pkg::CH_FF);
        put_char(tpf_pkg::CH_CR);
        put_run(tpf_pkg::CH_LF, int'(top_lines));
        put_run(tpf_pkg::CH_SP, int'(left_spaces));
      end
      tpf_pkg::ACT_DATA: begin
        if (!halted) begin
          case (db)
            tpf_pkg::CH_CR: begin
              put_char(db);
              col_pos = '0;
            end
            tpf_pkg::CH_LF: begin
              put_char(db);
              line_pos = line_pos + 1'b1;
              // past the page length: break the page and lay the top margin again
              if (line_pos > {1'b0, page_len}) begin
                put_char(tpf_pkg::CH_FF);
                put_run(tpf_pkg::CH_LF, int'(top_lines));
                line_pos = '0;
              end
              // pad up to the left margin; the column itself stays where it is
              if (col_pos < {11'd0, left_spaces}) begin
                put_run(tpf_pkg::CH_SP, int'(left_spaces) - int'(col_pos));
              end
            end
            tpf_pkg::CH_FF: begin
              put_char(tpf_pkg::CH_FF);
              put_char(tpf_pkg::CH_CR);
              col_pos = '0;
              put_run(tpf_pkg::CH_LF, int'(top_lines));
              put_run(tpf_pkg::CH_SP, int'(left_spaces));
              line_pos = '0;
            end
            tpf_pkg::CH_TAB: begin
              tab_fill = int'(tpf_pkg::TAB_STOP) - (int'(col_pos) % int'(tpf_pkg::TAB_STOP));
              put_run(tpf_pkg::CH_SP, tab_fill);
              col_pos = col_pos + 16'(tab_fill);
            end
            tpf_pkg::CH_EOF: begin
              put_char(tpf_pkg::CH_EOF);
              halted = 1'b1;
            end
            default: begin
              put_char(db);
              col_pos = col_pos + 1'b1;
            end
          endcase
        end
      end
      tpf_pkg::ACT_END: begin
        if (!halted) begin
          put_char(tpf_pkg::CH_FF);
          put_char(tpf_pkg::CH_EOF);
          halted = 1'b1;
        end
      end
      default: ;  // reserved action: taken, nothing printed
    endcase
    request_bytes = run_bytes.size();
    if (request_bytes > 0) begin
      tail     = run_bytes.pop_back();
      tail.fin = 1'b1;
      run_bytes.push_back(tail);
    end
    foreach (run_bytes[i]) printer_stream.push_back(run_bytes[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: one request per call, accepted on the handshake.
  // ---------------------------------------------------------------------------
  // Valid is left high after acceptance; it drops when the next request pauses or
  // settle runs, so back-to-back requests never see valid lowered and raised in one step.
  task automatic send_request(input logic [1:0] act, input logic [7:0] db);
    int gap;
    if (quiet_in || $urandom_range(0, 3) == 0) gap = 0;
    else gap = $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= db;
    do @(posedge clk); while (!(in_valid && in_ready));
    format_request(act, db);
  endtask

  // Drop valid and wait until every owed byte has come out, then let a
  // request that plans nothing retire too.
  task automatic settle();
    in_valid <= 1'b0;
    while (printer_stream.size() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  // Write every register, plus the unused index, on consecutive cycles.
  // Call only while the block is idle.
  task automatic apply_settings(input logic [7:0] top_w, input logic [7:0] left_w,
                                input logic [7:0] page_w);
    cfg_write <= 1'b1;
    cfg_index <= tpf_pkg::REG_TOP_MARGIN;
    cfg_data  <= top_w;
    @(posedge clk);
    cfg_index <= tpf_pkg::REG_LEFT_MARGIN;
    cfg_data  <= left_w;
    @(posedge clk);
    cfg_index <= tpf_pkg::REG_PAGE_LINES;
    cfg_data  <= page_w;
    @(posedge clk);
    cfg_index <= REG_UNUSED;
    cfg_data  <= 8'($urandom_range(0, 255));
    @(posedge clk);
    cfg_write   <= 1'b0;
    top_lines   = top_w[tpf_pkg::MargW-1:0];
    left_spaces = left_w[tpf_pkg::MargW-1:0];
    page_len    = page_w;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: stall before each byte, then hold ready until it is taken.
  // ---------------------------------------------------------------------------
  initial begin : printer_sink
    int stall;
    wait (rst == 1'b0);
    forever begin
      if (quiet_out || $urandom_range(0, 3) == 0) stall = 0;
      else stall = $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Compare each byte that leaves the block with the oldest one owed.
  always @(posedge clk) begin : byte_check
    print_byte_t owed;
    if (rst == 1'b0 && out_valid && out_ready) begin
      if (printer_stream.size() == 0) begin
        $display("%0t: unexpected byte, expected none, actual out_byte %h last %b",
                 $time, out_byte, last);
        mismatches++;
      end else begin
        owed = printer_stream.pop_front();
        if (out_byte !== owed.ch) begin
          $display("%0t: out_byte mismatch, expected %h, actual %h", $time, owed.ch, out_byte);
          mismatches++;
        end
        if (last !== owed.fin) begin
          $display("%0t: last mismatch, expected %b, actual %b", $time, owed.fin, last);
          mismatches++;
        end
      end
    end
  end

  // Hang detector: count cycles in which neither channel moves anything.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: margins 0, page length 60. Data before any start request is
  // printed with the reset state; the 61st line feed breaks the page.
  task automatic test_reset_defaults();
    send_request(tpf_pkg::ACT_DATA, "A");
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_TAB);
    send_request(tpf_pkg::ACT_START, 8'hA5);
    repeat (61) send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);
  endtask

  // Small margins and a short page: every control byte, field extremes,
  // the reserved action, and requests after a stop.
  task automatic test_margins_and_paging();
    settle();
    apply_settings(8'd2, 8'd3, 8'd2);
    send_request(tpf_pkg::ACT_START, 8'h00);
    send_request(tpf_pkg::ACT_DATA, "A");
    send_request(tpf_pkg::ACT_DATA, "B");
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_TAB);   // mid-stop tab
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);    // column past the margin: no padding
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_CR);
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);    // column 0: pad to the margin
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);    // third line: page break
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_FF);
    send_request(tpf_pkg::ACT_DATA, 8'h00);
    send_request(tpf_pkg::ACT_DATA, 8'hFF);
    send_request(ACT_RESERVED, 8'h5A);
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_TAB);   // tab from column 2: mid-stop
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_EOF);   // echoed, then stopped
    send_request(tpf_pkg::ACT_DATA, "Z");               // ignored
    send_request(tpf_pkg::ACT_END, 8'hFF);              // ignored
    send_request(ACT_RESERVED, 8'h00);
    send_request(tpf_pkg::ACT_START, 8'hFF);            // restarts after the stop
    send_request(tpf_pkg::ACT_END, 8'h00);
    send_request(tpf_pkg::ACT_DATA, "Q");               // ignored after end of input
    send_request(tpf_pkg::ACT_END, 8'h3C);              // ignored
  endtask

  // Largest margins with a zero page length: runs of the full 64 bytes.
  // Upper data bits of the margin writes must be dropped.
  task automatic test_margin_extremes();
    settle();
    apply_settings(8'hFF, 8'hFF, 8'h00);
    send_request(tpf_pkg::ACT_START, 8'h00);
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_FF);
    send_request(tpf_pkg::ACT_DATA, "x");
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);
    send_request(tpf_pkg::ACT_END, 8'h00);
  endtask

  // Tabs carry the column past the widest margin, so the line feed adds no
  // padding; after a carriage return the next line feed pads the whole margin.
  task automatic test_long_line();
    settle();
    apply_settings(8'd0, 8'd31, 8'd255);
    quiet_in  = 1'b1;
    quiet_out = 1'b1;
    send_request(tpf_pkg::ACT_START, 8'h00);
    repeat (5) send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_TAB);
    send_request(tpf_pkg::ACT_DATA, "k");
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_CR);
    send_request(tpf_pkg::ACT_DATA, tpf_pkg::CH_LF);
    send_request(tpf_pkg::ACT_END, 8'h00);
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  // Documents with random content under several settings. Most requests are
  // data bytes of a running document; starts, ends and reserved codes are noise.
  task automatic test_random_documents();
    int         printed;
    int         pick;
    logic [1:0] act;
    logic [7:0] db;
    for (int phase = 0; phase < 5; phase++) begin
      settle();
      case (phase)
        0: apply_settings(8'hFF, 8'hFF, 8'hFF);
        1: apply_settings(8'h00, 8'h00, 8'h00);
        default: apply_settings(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                            : 8'($urandom_range(0, 6)));
      endcase
      // one phase without any pauses on either side
      quiet_in  = (phase == 3);
      quiet_out = (phase == 3);
      send_request(tpf_pkg::ACT_START, 8'($urandom_range(0, 255)));
      printed = 0;
      while (printed < 30) begin
        db   = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (halted && $urandom_range(0, 1) == 0) act = tpf_pkg::ACT_START;
        else if (pick < 3) act = tpf_pkg::ACT_START;
        else if (pick < 6) act = tpf_pkg::ACT_END;
        else if (pick < 8) act = ACT_RESERVED;
        else begin
          act  = tpf_pkg::ACT_DATA;
          pick = $urandom_range(0, 99);
          if (pick < 12) db = tpf_pkg::CH_LF;
          else if (pick < 18) db = tpf_pkg::CH_CR;
          else if (pick < 21) db = tpf_pkg::CH_FF;
          else if (pick < 30) db = tpf_pkg::CH_TAB;
          else if (pick < 32) db = tpf_pkg::CH_EOF;
        end
        send_request(act, db);
        if (request_bytes > 0) printed++;
      end
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_printer();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_margins_and_paging();
    test_margin_extremes();
    test_long_line();
    test_random_documents();

    // drain, then watch a while longer for stray bytes
    settle();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && printer_stream.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
